/* rtl/cms_pkg.sv */
package cms_pkg;

   // sizing of the sample path
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 1024;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);         // kept count, 0..MAX_SAMPLES
   localparam int ADDR_W = $clog2(MAX_SAMPLES);             // store address
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;             // signed running sum
   localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;         // sum of squares
   localparam int P_W    = 2 * SAMPLE_BITS + 2 * CNT_W;     // n*sum(x^2), (sum x)^2
   localparam int D_W    = P_W + 1;                         // summed distances of both parts
   localparam int DEN_W  = 2 * CNT_W;                       // n*(n-1)
   localparam int STD_W  = SAMPLE_BITS + 1;                 // standard deviation
   localparam int MB_W   = SUM_W;                           // multiplier operand B

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_re;
      logic signed [SAMPLE_BITS-1:0] sample_im;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mean_re;
      logic signed [SAMPLE_BITS-1:0] mean_im;
      logic [STD_W-1:0]              std_dev;
      logic [CNT_W-1:0]              sample_count;
      logic                          overflowed;
   } rsp_type;

   // products formed by the shared shift-add multiplier
   typedef enum logic [2:0] {
      MUL_NSQ_RE,
      MUL_NSQ_IM,
      MUL_SUM_RE,
      MUL_SUM_IM,
      MUL_DEN
   } mul_op_type;

   // quotients formed by the shared divider
   typedef enum logic [1:0] {
      DIV_MEAN_RE,
      DIV_MEAN_IM,
      DIV_VAR
   } div_op_type;

   typedef struct packed {
      logic       store;
      logic       close;
      logic       pass_start;
      logic       mul_start;
      mul_op_type mul_op;
      logic       div_start;
      div_op_type div_op;
      logic       sqrt_start;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic pass_busy;
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic single;
      logic out_free;
   } dp_stat_type;

endpackage

/* rtl/cms_div.sv */
// restoring divider, one quotient bit per cycle
module cms_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cms_pkg::D_W-1:0]    num,
   input  logic [cms_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [cms_pkg::D_W-1:0]    quo
);

   localparam int D_W   = cms_pkg::D_W;
   localparam int DEN_W = cms_pkg::DEN_W;
   localparam int CW    = $clog2(D_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [D_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             act_ff, act_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[D_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      act_in  = act_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = CW'(D_W);
         act_in = 1'b1;
      end else if (act_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[D_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/cms_sqrt.sv */
// bit-pair integer square root, one result bit per cycle
module cms_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cms_pkg::D_W-1:0]    val,
   output logic                       done,
   output logic [cms_pkg::STD_W-1:0]  root
);

   localparam int D_W = cms_pkg::D_W;
   localparam int R_W = (D_W + 1) / 2;
   localparam logic [D_W-1:0] STEP_INIT = D_W'(1) << (2 * (R_W - 1));

   logic [D_W-1:0] x_ff, x_in;
   logic [D_W-1:0] res_ff, res_in;
   logic [D_W-1:0] step_ff, step_in;
   logic           act_ff, act_in;
   logic           done_ff, done_in;

   logic [D_W-1:0] trial;
   logic           ge;

   assign trial = res_ff + step_ff;
   assign ge    = x_ff >= trial;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      step_in = step_ff;
      act_in  = act_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = val;
         res_in  = '0;
         step_in = STEP_INIT;
         act_in  = 1'b1;
      end else if (act_ff) begin
         if (ge) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + step_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         step_in = step_ff >> 2;
         if (step_ff[0]) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      res_ff  <= res_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = res_ff[cms_pkg::STD_W-1:0];

endmodule

/* rtl/cms_dpath.sv */
// sample store, running sums, square pass, shared multiplier, divider, square root,
// result register
module cms_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  cms_pkg::dp_cmd_type  cmd,
   output cms_pkg::dp_stat_type stat,
   input  cms_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cms_pkg::rsp_type     rsp_data
);

   localparam int SB     = cms_pkg::SAMPLE_BITS;
   localparam int CNT_W  = cms_pkg::CNT_W;
   localparam int ADDR_W = cms_pkg::ADDR_W;
   localparam int SUM_W  = cms_pkg::SUM_W;
   localparam int SQ_W   = cms_pkg::SQ_W;
   localparam int P_W    = cms_pkg::P_W;
   localparam int D_W    = cms_pkg::D_W;
   localparam int DEN_W  = cms_pkg::DEN_W;
   localparam int STD_W  = cms_pkg::STD_W;
   localparam int MB_W   = cms_pkg::MB_W;
   localparam int MCNT_W = $clog2(MB_W + 1);

   // ---- set accumulation ----
   logic signed [SUM_W-1:0] sum_re_ff, sum_re_in;
   logic signed [SUM_W-1:0] sum_im_ff, sum_im_in;
   logic [CNT_W-1:0]        kept_ff, kept_in;
   logic                    drop_ff, drop_in;
   logic                    room;
   logic                    mem_we;

   logic [2*SB-1:0]         mem [cms_pkg::MAX_SAMPLES];
   logic [2*SB-1:0]         rd_data_ff;

   assign room   = kept_ff < CNT_W'(cms_pkg::MAX_SAMPLES);
   assign mem_we = cmd.store && room;

   always_comb begin
      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      kept_in   = kept_ff;
      drop_in   = drop_ff;
      if (cmd.emit) begin
         sum_re_in = '0;
         sum_im_in = '0;
         kept_in   = '0;
         drop_in   = 1'b0;
      end else if (cmd.store) begin
         if (room) begin
            sum_re_in = sum_re_ff + SUM_W'(req_data.sample_re);
            sum_im_in = sum_im_ff + SUM_W'(req_data.sample_im);
            kept_in   = kept_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   // ---- square pass over the store ----
   logic [CNT_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                   pass_act_ff, pass_act_in;
   logic                   rd_vld_ff;
   logic signed [SB-1:0]   rd_re, rd_im;
   logic signed [2*SB-1:0] sqr_re, sqr_im;
   logic [2*SB-1:0]        prod_re_ff, prod_im_ff;
   logic                   prod_vld_ff;
   logic [SQ_W-1:0]        sq_re_ff, sq_re_in;
   logic [SQ_W-1:0]        sq_im_ff, sq_im_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[kept_ff[ADDR_W-1:0]] <= {req_data.sample_im, req_data.sample_re};
      end
      rd_data_ff <= mem[rd_addr_ff[ADDR_W-1:0]];
   end

   assign rd_re  = rd_data_ff[SB-1:0];
   assign rd_im  = rd_data_ff[2*SB-1:SB];
   assign sqr_re = rd_re * rd_re;
   assign sqr_im = rd_im * rd_im;

   always_comb begin
      rd_addr_in  = rd_addr_ff;
      pass_act_in = pass_act_ff;
      sq_re_in    = sq_re_ff;
      sq_im_in    = sq_im_ff;
      if (cmd.pass_start) begin
         rd_addr_in  = '0;
         pass_act_in = 1'b1;
         sq_re_in    = '0;
         sq_im_in    = '0;
      end else begin
         if (pass_act_ff) begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == kept_ff - 1'b1) begin
               pass_act_in = 1'b0;
            end
         end
         if (prod_vld_ff) begin
            sq_re_in = sq_re_ff + SQ_W'(prod_re_ff);
            sq_im_in = sq_im_ff + SQ_W'(prod_im_ff);
         end
      end
   end

   // ---- shared shift-add multiplier ----
   logic [SUM_W-1:0]    abs_re, abs_im;
   logic [P_W-1:0]      mop_a;
   logic [MB_W-1:0]     mop_b;
   logic [P_W-1:0]      mul_a_ff, mul_a_in;
   logic [MB_W-1:0]     mul_b_ff, mul_b_in;
   logic [P_W-1:0]      mul_acc_ff, mul_acc_in;
   logic [MCNT_W-1:0]   mul_cnt_ff, mul_cnt_in;
   logic                mul_act_ff, mul_act_in;
   logic                mul_done_ff, mul_done_in;
   cms_pkg::mul_op_type mul_op_ff, mul_op_in;

   assign abs_re = sum_re_ff[SUM_W-1] ? -sum_re_ff : sum_re_ff;
   assign abs_im = sum_im_ff[SUM_W-1] ? -sum_im_ff : sum_im_ff;

   always_comb begin
      case (cmd.mul_op)
         cms_pkg::MUL_NSQ_RE: begin
            mop_a = P_W'(sq_re_ff);
            mop_b = MB_W'(kept_ff);
         end
         cms_pkg::MUL_NSQ_IM: begin
            mop_a = P_W'(sq_im_ff);
            mop_b = MB_W'(kept_ff);
         end
         cms_pkg::MUL_SUM_RE: begin
            mop_a = P_W'(abs_re);
            mop_b = abs_re;
         end
         cms_pkg::MUL_SUM_IM: begin
            mop_a = P_W'(abs_im);
            mop_b = abs_im;
         end
         cms_pkg::MUL_DEN: begin
            mop_a = P_W'(kept_ff);
            mop_b = MB_W'(kept_ff - 1'b1);
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   always_comb begin
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      mul_acc_in  = mul_acc_ff;
      mul_cnt_in  = mul_cnt_ff;
      mul_act_in  = mul_act_ff;
      mul_op_in   = mul_op_ff;
      mul_done_in = 1'b0;
      if (cmd.mul_start) begin
         mul_a_in   = mop_a;
         mul_b_in   = mop_b;
         mul_acc_in = '0;
         mul_cnt_in = MCNT_W'(MB_W);
         mul_act_in = 1'b1;
         mul_op_in  = cmd.mul_op;
      end else if (mul_act_ff) begin
         if (mul_b_ff[0]) begin
            mul_acc_in = mul_acc_ff + mul_a_ff;
         end
         mul_a_in   = mul_a_ff << 1;
         mul_b_in   = mul_b_ff >> 1;
         mul_cnt_in = mul_cnt_ff - 1'b1;
         if (mul_cnt_ff == MCNT_W'(1)) begin
            mul_act_in  = 1'b0;
            mul_done_in = 1'b1;
         end
      end
   end

   // ---- distance sum and denominator ----
   logic [D_W-1:0]   dist_ff, dist_in;
   logic [DEN_W-1:0] den_ff, den_in;

   always_comb begin
      dist_in = dist_ff;
      den_in  = den_ff;
      if (cmd.close) begin
         dist_in = '0;
      end else if (mul_done_ff) begin
         case (mul_op_ff) inside
            cms_pkg::MUL_NSQ_RE, cms_pkg::MUL_NSQ_IM: dist_in = dist_ff + D_W'(mul_acc_ff);
            cms_pkg::MUL_SUM_RE, cms_pkg::MUL_SUM_IM: dist_in = dist_ff - D_W'(mul_acc_ff);
            cms_pkg::MUL_DEN:                         den_in  = mul_acc_ff[DEN_W-1:0];
            default:                                  dist_in = dist_ff;
         endcase
      end
   end

   // ---- divider: means and variance ----
   logic [D_W-1:0]      div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done;
   logic [D_W-1:0]      div_quo;
   logic [SB-1:0]       q_lo;
   cms_pkg::div_op_type div_op_ff, div_op_in;
   logic [SB-1:0]       mean_re_ff, mean_re_in;
   logic [SB-1:0]       mean_im_ff, mean_im_in;
   logic [D_W-1:0]      var_ff, var_in;

   always_comb begin
      case (cmd.div_op)
         cms_pkg::DIV_MEAN_RE: begin
            div_num = D_W'(abs_re);
            div_den = DEN_W'(kept_ff);
         end
         cms_pkg::DIV_MEAN_IM: begin
            div_num = D_W'(abs_im);
            div_den = DEN_W'(kept_ff);
         end
         cms_pkg::DIV_VAR: begin
            div_num = dist_ff;
            div_den = den_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   cms_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign q_lo = div_quo[SB-1:0];

   always_comb begin
      div_op_in  = div_op_ff;
      mean_re_in = mean_re_ff;
      mean_im_in = mean_im_ff;
      var_in     = var_ff;
      if (cmd.div_start) begin
         div_op_in = cmd.div_op;
      end
      if (div_done) begin
         case (div_op_ff)
            cms_pkg::DIV_MEAN_RE: mean_re_in = sum_re_ff[SUM_W-1] ? -q_lo : q_lo;
            cms_pkg::DIV_MEAN_IM: mean_im_in = sum_im_ff[SUM_W-1] ? -q_lo : q_lo;
            cms_pkg::DIV_VAR:     var_in     = div_quo;
            default:              var_in     = var_ff;
         endcase
      end
   end

   // ---- square root ----
   logic             sqrt_done;
   logic [STD_W-1:0] sqrt_root;
   logic [STD_W-1:0] std_ff, std_in;

   cms_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .val   (var_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_comb begin
      std_in = std_ff;
      if (cmd.close) begin
         std_in = '0;
      end else if (sqrt_done) begin
         std_in = sqrt_root;
      end
   end

   // ---- result register ----
   cms_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_in.mean_re      = mean_re_ff;
         rsp_in.mean_im      = mean_im_ff;
         rsp_in.std_dev      = std_ff;
         rsp_in.sample_count = kept_ff;
         rsp_in.overflowed   = drop_ff;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_re_ff    <= '0;
         sum_im_ff    <= '0;
         kept_ff      <= '0;
         drop_ff      <= 1'b0;
         pass_act_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         mul_act_ff   <= 1'b0;
         mul_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_re_ff    <= sum_re_in;
         sum_im_ff    <= sum_im_in;
         kept_ff      <= kept_in;
         drop_ff      <= drop_in;
         pass_act_ff  <= pass_act_in;
         rd_vld_ff    <= pass_act_ff;
         prod_vld_ff  <= rd_vld_ff;
         mul_act_ff   <= mul_act_in;
         mul_done_ff  <= mul_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      prod_re_ff <= sqr_re;
      prod_im_ff <= sqr_im;
      sq_re_ff   <= sq_re_in;
      sq_im_ff   <= sq_im_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      mul_cnt_ff <= mul_cnt_in;
      mul_op_ff  <= mul_op_in;
      dist_ff    <= dist_in;
      den_ff     <= den_in;
      div_op_ff  <= div_op_in;
      mean_re_ff <= mean_re_in;
      mean_im_ff <= mean_im_in;
      var_ff     <= var_in;
      std_ff     <= std_in;
      rsp_ff     <= rsp_in;
   end

   assign stat.pass_busy = pass_act_ff || rd_vld_ff || prod_vld_ff;
   assign stat.mul_done  = mul_done_ff;
   assign stat.div_done  = div_done;
   assign stat.sqrt_done = sqrt_done;
   assign stat.single    = kept_ff == CNT_W'(1);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/cms_ctrl.sv */
// sequencer: load, means, square pass, products, variance, root, result
module cms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output cms_pkg::dp_cmd_type  cmd,
   input  cms_pkg::dp_stat_type stat
);

   typedef enum logic [9:0] {
      ST_LOAD      = 10'b0000000001,
      ST_DIV_GO    = 10'b0000000010,
      ST_DIV_WAIT  = 10'b0000000100,
      ST_PASS_GO   = 10'b0000001000,
      ST_PASS      = 10'b0000010000,
      ST_MUL_GO    = 10'b0000100000,
      ST_MUL_WAIT  = 10'b0001000000,
      ST_SQRT_GO   = 10'b0010000000,
      ST_SQRT_WAIT = 10'b0100000000,
      ST_EMIT      = 10'b1000000000
   } ctrl_state_type;

   ctrl_state_type      state_ff, state_in;
   cms_pkg::mul_op_type mul_op_ff, mul_op_in;
   cms_pkg::div_op_type div_op_ff, div_op_in;

   always_comb begin
      state_in   = state_ff;
      mul_op_in  = mul_op_ff;
      div_op_in  = div_op_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.mul_op = mul_op_ff;
      cmd.div_op = div_op_ff;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  cmd.close = 1'b1;
                  div_op_in = cms_pkg::DIV_MEAN_RE;
                  state_in  = ST_DIV_GO;
               end
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               case (div_op_ff)
                  cms_pkg::DIV_MEAN_RE: begin
                     div_op_in = cms_pkg::DIV_MEAN_IM;
                     state_in  = ST_DIV_GO;
                  end
                  cms_pkg::DIV_MEAN_IM: state_in = stat.single ? ST_EMIT : ST_PASS_GO;
                  cms_pkg::DIV_VAR:     state_in = ST_SQRT_GO;
                  default:              state_in = ST_EMIT;
               endcase
            end
         end
         ST_PASS_GO: begin
            cmd.pass_start = 1'b1;
            mul_op_in      = cms_pkg::MUL_NSQ_RE;
            state_in       = ST_PASS;
         end
         ST_PASS: begin
            if (!stat.pass_busy) begin
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               state_in = ST_MUL_GO;
               case (mul_op_ff)
                  cms_pkg::MUL_NSQ_RE: mul_op_in = cms_pkg::MUL_NSQ_IM;
                  cms_pkg::MUL_NSQ_IM: mul_op_in = cms_pkg::MUL_SUM_RE;
                  cms_pkg::MUL_SUM_RE: mul_op_in = cms_pkg::MUL_SUM_IM;
                  cms_pkg::MUL_SUM_IM: mul_op_in = cms_pkg::MUL_DEN;
                  default: begin
                     div_op_in = cms_pkg::DIV_VAR;
                     state_in  = ST_DIV_GO;
                  end
               endcase
            end
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (stat.sqrt_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         mul_op_ff <= cms_pkg::MUL_NSQ_RE;
         div_op_ff <= cms_pkg::DIV_MEAN_RE;
      end else begin
         state_ff  <= state_in;
         mul_op_ff <= mul_op_in;
         div_op_ff <= div_op_in;
      end
   end

endmodule

/* rtl/complex_mean_stddev.sv */
// channel  direction  handshake            payload
// req_     in         req_valid/req_stall  cms_pkg::req_type: one complex sample + last flag
// rsp_     out        rsp_valid/rsp_stall  cms_pkg::rsp_type: means, std dev, count, drop flag
//
// Cycles: one per sample item while loading; req_stall is high during the result run.
// The last item starts the result run: two means on the serial divider; for n > 1 a pass
// over the store, five shift-add products, variance division, root; for n = 1 just the means.
// Reset: synchronous; clears sums, count and drop flag; the store needs no clearing.
// Stalls: rsp_stall holds the result register; the next set loads meanwhile and only
// its final result waits for the register to free up.
module complex_mean_stddev (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cms_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cms_pkg::dp_cmd_type  cmd;
   cms_pkg::dp_stat_type stat;

   // sequencer: owns the input handshake and steps the datapath units in order
   cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_sample),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: sample store, sums, square pass, multiplier, divider, root, result reg
   cms_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
